@@ sv/utba_pkg.sv @@
// Shared constants, types and command codes of the unit table block allocator.
package utba_pkg;

   localparam int UNITS      = 1024;
   localparam int UNIT_BYTES = 32;
   localparam int IDX_W      = $clog2(UNITS);
   localparam int PTR_W      = IDX_W + 1;
   localparam int UB_SHIFT   = $clog2(UNIT_BYTES);
   localparam int RSVD_UNITS = (UNITS + UNIT_BYTES - 1) / UNIT_BYTES;
   localparam longint POOL_BYTES = longint'(UNITS) * longint'(UNIT_BYTES);
   localparam int NEED_W     = 17;
   localparam int DIST_W     = 7;

   localparam logic [1:0] CLS_FREE = 2'b00;
   localparam logic [1:0] CLS_BODY = 2'b01;
   localparam logic [1:0] CLS_RSVD = 2'b10;
   localparam logic [1:0] CLS_END  = 2'b11;
   localparam logic [5:0] DIST_MAX = 6'd63;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_A_RD, ST_A_EV, ST_M_WR, ST_N_RD, ST_N_EV, ST_E_WR,
      ST_F_RD, ST_F_EV, ST_S_RD, ST_S_EV, ST_C_WR, ST_R_CHK, ST_R_RD, ST_R_EV,
      ST_B_RD, ST_B_EV, ST_OK, ST_FAIL, ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CLR, OP_ACCEPT, OP_ARD, OP_AHIT, OP_ARUN, OP_ASKIP, OP_MWR,
      OP_NINIT, OP_NSET, OP_NRD, OP_NFOUND, OP_NINC, OP_EWR, OP_FRD, OP_SRD,
      OP_SSET, OP_DEC, OP_CWR, OP_RINIT, OP_RRD, OP_RWR, OP_OK, OP_FAIL, OP_EMIT
   } op_type;

   typedef struct packed {
      logic [1:0] cls;
      logic       ent_zero;
      logic       hit;
      logic       ptr_ovf;
      logic       ptr_at_end;
      logic       ptr_zero;
      logic       start_zero;
      logic       n_ovf;
      logic       n_cap;
      logic       req_bad;
      logic       req_free;
      logic       clr_last;
      logic       rsp_free;
   } dp_status_type;

endpackage

@@ sv/utba_ctrl.sv @@
// Controller state machine of the unit table block allocator.
module utba_ctrl import utba_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type st,
   output op_type        op
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op        = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            op = OP_CLR;
            if (st.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op = OP_ACCEPT;
               if (st.req_bad) state_in = ST_FAIL;
               else if (st.req_free) state_in = ST_F_RD;
               else state_in = ST_A_RD;
            end
         end
         ST_A_RD: begin
            if (st.ptr_ovf) begin
               state_in = ST_FAIL;
            end else begin
               op = OP_ARD;
               state_in = ST_A_EV;
            end
         end
         ST_A_EV: begin
            if (st.ent_zero) begin
               if (st.hit) begin
                  op = OP_AHIT;
                  state_in = ST_M_WR;
               end else begin
                  op = OP_ARUN;
                  state_in = ST_A_RD;
               end
            end else if (st.cls == CLS_RSVD) begin
               state_in = ST_FAIL;
            end else begin
               op = OP_ASKIP;
               state_in = ST_A_RD;
            end
         end
         ST_M_WR: begin
            if (st.ptr_at_end) begin
               op = OP_NINIT;
               state_in = ST_N_RD;
            end else begin
               op = OP_MWR;
            end
         end
         ST_N_RD: begin
            if (st.n_cap || st.n_ovf) begin
               op = OP_NSET;
               state_in = ST_E_WR;
            end else begin
               op = OP_NRD;
               state_in = ST_N_EV;
            end
         end
         ST_N_EV: begin
            if (st.ent_zero) begin
               op = OP_NFOUND;
               state_in = ST_E_WR;
            end else begin
               op = OP_NINC;
               state_in = ST_N_RD;
            end
         end
         ST_E_WR: begin
            op = OP_EWR;
            state_in = ST_DONE;
         end
         ST_F_RD: begin
            op = OP_FRD;
            state_in = ST_F_EV;
         end
         ST_F_EV: begin
            if (st.cls != CLS_END) state_in = ST_FAIL;
            else state_in = ST_S_RD;
         end
         ST_S_RD: begin
            if (st.ptr_zero) begin
               op = OP_SSET;
               state_in = ST_C_WR;
            end else begin
               op = OP_SRD;
               state_in = ST_S_EV;
            end
         end
         ST_S_EV: begin
            if (st.cls == CLS_END || st.cls == CLS_FREE) begin
               op = OP_SSET;
               state_in = ST_C_WR;
            end else begin
               op = OP_DEC;
               state_in = ST_S_RD;
            end
         end
         ST_C_WR: begin
            op = OP_CWR;
            if (st.ptr_at_end) state_in = ST_R_CHK;
         end
         ST_R_CHK: begin
            if (st.start_zero) begin
               op = OP_OK;
               state_in = ST_DONE;
            end else begin
               op = OP_RINIT;
               state_in = ST_R_RD;
            end
         end
         ST_R_RD: begin
            op = OP_RRD;
            state_in = ST_R_EV;
         end
         ST_R_EV: begin
            if (st.cls != CLS_END) begin
               op = OP_OK;
               state_in = ST_DONE;
            end else begin
               op = OP_RWR;
               state_in = st.ptr_zero ? ST_OK : ST_B_RD;
            end
         end
         ST_B_RD: begin
            op = OP_RRD;
            state_in = ST_B_EV;
         end
         ST_B_EV: begin
            if (st.cls == CLS_BODY) begin
               if (st.ptr_zero) begin
                  state_in = ST_OK;
               end else begin
                  op = OP_DEC;
                  state_in = ST_B_RD;
               end
            end else begin
               state_in = ST_R_EV;
            end
         end
         ST_OK: begin
            op = OP_OK;
            state_in = ST_DONE;
         end
         ST_FAIL: begin
            op = OP_FAIL;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (st.rsp_free) begin
               op = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

@@ sv/utba_dp.sv @@
// Datapath of the unit table block allocator: table memory, pointers, result register.
module utba_dp import utba_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  op_type        op,
   output dp_status_type st,
   input  logic          csr_we,
   input  logic [31:0]   csr_wdata,
   input  logic          req_mode,
   input  logic [15:0]   req_request_bytes,
   input  logic [31:0]   req_free_address,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_status,
   output logic [31:0]   rsp_block_address
);

   logic [7:0]        mem [UNITS];
   logic [7:0]        rdata_ff;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [PTR_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  start_ff, start_in;
   logic [IDX_W-1:0]  end_ff, end_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [5:0]        enddist_ff, enddist_in;
   logic [31:0]       pool_base_ff;
   logic              res_status_ff, res_status_in;
   logic [31:0]       res_addr_ff, res_addr_in;
   logic              rsp_valid_ff;
   logic              rsp_status_ff;
   logic [31:0]       rsp_addr_ff;

   logic              we, re;
   logic [IDX_W-1:0]  wa, ra;
   logic [7:0]        wd;
   logic [31:0]       off;
   logic [IDX_W-1:0]  free_idx;
   logic [IDX_W-1:0]  ptr_idx;
   logic [IDX_W-1:0]  body_diff, left_diff;
   logic [5:0]        body_dist, left_dist, skip;
   logic [PTR_W:0]    probe;
   logic [IDX_W-1:0]  addr_units;

   assign ptr_idx  = ptr_ff[IDX_W-1:0];
   assign off      = req_free_address - pool_base_ff;
   assign free_idx = IDX_W'(UNITS - 1) - off[UB_SHIFT +: IDX_W];
   assign body_diff = end_ff - ptr_idx;
   assign body_dist = (body_diff > IDX_W'(DIST_MAX)) ? DIST_MAX : body_diff[5:0];
   assign left_diff = start_ff - ptr_idx;
   assign left_dist = (left_diff > IDX_W'(DIST_MAX)) ? DIST_MAX : left_diff[5:0];
   assign skip      = rdata_ff[5:0];
   assign probe     = (PTR_W+1)'(end_ff) + (PTR_W+1)'(dist_ff);
   assign addr_units = IDX_W'(UNITS - 1) - end_ff;

   always_comb begin
      st.cls        = rdata_ff[7:6];
      st.ent_zero   = (rdata_ff == 8'd0);
      st.hit        = ((NEED_W'(count_ff) + NEED_W'(1)) == need_ff);
      st.ptr_ovf    = ptr_ff[IDX_W];
      st.ptr_at_end = (ptr_idx == end_ff);
      st.ptr_zero   = (ptr_ff == '0);
      st.start_zero = (start_ff == '0);
      st.n_ovf      = (probe >= (PTR_W+1)'(UNITS));
      st.n_cap      = (dist_ff == DIST_W'(64));
      st.req_free   = req_mode;
      if (req_mode) begin
         st.req_bad = (req_free_address == 32'd0) ||
                      ({32'd0, off} >= 64'(POOL_BYTES)) ||
                      (off[UB_SHIFT-1:0] != '0);
      end else begin
         st.req_bad = (req_request_bytes == 16'd0);
      end
      st.clr_last   = (ptr_idx == IDX_W'(UNITS - 1));
      st.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // Decode the command into memory strobes and register next values.
   always_comb begin
      we = 1'b0;
      re = 1'b0;
      wa = ptr_idx;
      ra = ptr_idx;
      wd = 8'd0;
      ptr_in        = ptr_ff;
      count_in      = count_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      need_in       = need_ff;
      dist_in       = dist_ff;
      enddist_in    = enddist_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      case (op)
         OP_CLR: begin
            we = 1'b1;
            wd = (ptr_idx >= IDX_W'(UNITS - RSVD_UNITS)) ? {CLS_RSVD, 6'd0} : 8'd0;
            ptr_in = ptr_ff + PTR_W'(1);
         end
         OP_ACCEPT: begin
            count_in = '0;
            end_in   = free_idx;
            need_in  = (NEED_W'(req_request_bytes) + NEED_W'(UNIT_BYTES - 1)) >> UB_SHIFT;
            ptr_in   = req_mode ? PTR_W'(free_idx) : '0;
         end
         OP_ARD, OP_RRD: re = 1'b1;
         OP_AHIT: begin
            end_in = ptr_idx;
            ptr_in = (count_ff == '0) ? ptr_ff : PTR_W'(start_ff);
         end
         OP_ARUN: begin
            if (count_ff == '0) start_in = ptr_idx;
            count_in = count_ff + PTR_W'(1);
            ptr_in   = ptr_ff + PTR_W'(1);
         end
         OP_ASKIP: begin
            ptr_in   = ptr_ff + ((skip == 6'd0) ? PTR_W'(1) : PTR_W'(skip));
            count_in = '0;
         end
         OP_MWR: begin
            we = 1'b1;
            wd = {CLS_BODY, body_dist};
            ptr_in = ptr_ff + PTR_W'(1);
         end
         OP_NINIT:  dist_in = DIST_W'(1);
         OP_NSET:   enddist_in = st.n_cap ? DIST_MAX : 6'd0;
         OP_NRD: begin
            re = 1'b1;
            ra = probe[IDX_W-1:0];
         end
         OP_NFOUND: enddist_in = dist_ff[5:0];
         OP_NINC:   dist_in = dist_ff + DIST_W'(1);
         OP_EWR: begin
            we = 1'b1;
            wa = end_ff;
            wd = {CLS_END, enddist_ff};
            res_status_in = 1'b0;
            res_addr_in   = pool_base_ff + (32'(addr_units) << UB_SHIFT);
         end
         OP_FRD: begin
            re = 1'b1;
            ra = end_ff;
         end
         OP_SRD: begin
            re = 1'b1;
            ra = ptr_idx - IDX_W'(1);
         end
         OP_SSET: start_in = ptr_idx;
         OP_DEC:  ptr_in = ptr_ff - PTR_W'(1);
         OP_CWR: begin
            we = 1'b1;
            ptr_in = ptr_ff + PTR_W'(1);
         end
         OP_RINIT: ptr_in = PTR_W'(start_ff) - PTR_W'(1);
         OP_RWR: begin
            we = 1'b1;
            wd = {CLS_END, left_dist};
            ptr_in = ptr_ff - PTR_W'(1);
         end
         OP_OK: begin
            res_status_in = 1'b0;
            res_addr_in   = 32'd0;
         end
         OP_FAIL: begin
            res_status_in = 1'b1;
            res_addr_in   = 32'd0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      if (re) rdata_ff <= mem[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         pool_base_ff <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff <= ptr_in;
         if (csr_we) pool_base_ff <= csr_wdata;
         if (op == OP_EMIT) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      need_ff       <= need_in;
      dist_ff       <= dist_in;
      enddist_ff    <= enddist_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      if (op == OP_EMIT) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_addr_ff;

endmodule

@@ sv/unit_table_block_allocator.sv @@
// Top level of the unit table block allocator: controller plus datapath.
// A first-fit allocator over a 1024-entry table, one byte per 32-byte unit of the
// pool that starts at pool_base (csr_wdata, written with csr_we while idle, a rule
// the user must keep, as the block leaves it unchecked). After reset a clearing
// pass writes all 1024 table entries (top 32 entries reserved); no request beat is
// taken until it ends. Each request then walks the table through the memory: an
// allocate scans for a free run, marks the units of the block and probes for the
// next free unit (at most 63 probes), and a free walks to the block start, clears
// its units, refreshes the end entries of the blocks to its left and steps over
// interior units on the way left. A zero-size request or a bad address fails
// without a table walk. A finished result sits in the output register, so the
// next request beat is taken while the previous response beat still waits for
// rsp_ready.
module unit_table_block_allocator import utba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [15:0] req_request_bytes,
   input  logic [31:0] req_free_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [31:0] rsp_block_address
);

   op_type        op;
   dp_status_type st;

   // Sequence the table walks.
   utba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .op        (op)
   );

   // Hold the table, pointers and result beat.
   utba_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .st                (st),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_mode          (req_mode),
      .req_request_bytes (req_request_bytes),
      .req_free_address  (req_free_address),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address)
   );

endmodule

@@ sim/utba_checker.sv @@
// Checker of the unit table block allocator: table predictor and response compare.
`timescale 1ns / 100ps
module utba_checker import utba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_mode,
   input  logic [15:0] req_request_bytes,
   input  logic [31:0] req_free_address,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_status,
   input  logic [31:0] rsp_block_address,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic        status;
      logic [31:0] addr;
   } alloc_result_type;

   logic [7:0]       unit_map [UNITS];
   logic [31:0]      base_addr;
   alloc_result_type want_q [$];

   assign pending_count = want_q.size();

   function automatic logic [31:0] unit_addr(int idx);
      longint off;
      off = longint'(UNITS - 1 - idx) * UNIT_BYTES;
      return 32'(longint'(base_addr) + off);
   endfunction

   function automatic logic [5:0] free_dist(int e);
      for (int i = 1; i <= 63; i++) begin
         if (e + i >= UNITS) return 6'd0;
         if (unit_map[e + i] == 8'h00) return 6'(i);
      end
      return DIST_MAX;
   endfunction

   function automatic alloc_result_type do_alloc(logic [15:0] nbytes);
      alloc_result_type r;
      int need, i, cnt, st, d;
      r = '{1'b1, 32'd0};
      i = 0; cnt = 0; st = 0;
      if (nbytes == 0) return r;
      need = (int'(nbytes) + UNIT_BYTES - 1) / UNIT_BYTES;
      while (i < UNITS) begin
         if (unit_map[i] == 8'h00) begin
            if (cnt == 0) st = i;
            cnt++;
            if (cnt == need) begin
               for (int p = st; p < i; p++) begin
                  d = (i - p > 63) ? 63 : i - p;
                  unit_map[p] = {CLS_BODY, 6'(d)};
               end
               unit_map[i] = {CLS_END, free_dist(i)};
               r = '{1'b0, unit_addr(i)};
               return r;
            end
            i++;
         end else begin
            if (unit_map[i][7:6] == CLS_RSVD) return r;
            i += (unit_map[i][5:0] == 0) ? 1 : int'(unit_map[i][5:0]);
            cnt = 0;
         end
      end
      return r;
   endfunction

   function automatic alloc_result_type do_free(logic [31:0] a);
      alloc_result_type r;
      logic [31:0] off;
      int idx, s, cur, d;
      r = '{1'b1, 32'd0};
      if (a == 0) return r;
      off = a - base_addr;
      if (longint'(off) >= POOL_BYTES || off[UB_SHIFT-1:0] != 0) return r;
      idx = int'((POOL_BYTES - longint'(off)) / UNIT_BYTES) - 1;
      if (unit_map[idx][7:6] != CLS_END) return r;
      s = idx;
      while (s != 0 && unit_map[s-1][7:6] != CLS_END && unit_map[s-1][7:6] != CLS_FREE)
         s--;
      for (int p = s; p <= idx; p++) unit_map[p] = 8'h00;
      // refresh end entries of the chain of blocks to the left
      cur = s - 1;
      while (cur >= 0) begin
         if (unit_map[cur][7:6] != CLS_END) break;
         d = (s - cur > 63) ? 63 : s - cur;
         unit_map[cur] = {CLS_END, 6'(d)};
         cur--;
         while (cur >= 0 && unit_map[cur][7:6] == CLS_BODY) cur--;
      end
      r.status = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type got, want;
      if (reset) begin
         for (int i = 0; i < UNITS; i++)
            unit_map[i] = (i >= UNITS - RSVD_UNITS) ? {CLS_RSVD, 6'd0} : 8'h00;
         base_addr = 32'd0;
         want_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) base_addr = csr_wdata;
         if (req_valid && req_ready)
            want_q.push_back(req_mode ? do_free(req_free_address)
                                      : do_alloc(req_request_bytes));
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_status, rsp_block_address};
            if (want_q.size() == 0) begin
               $display("%0t: unexpected response beat status=%0d addr=%h",
                        $time, got.status, got.addr);
               fail_count <= fail_count + 1;
            end else begin
               want = want_q.pop_front();
               if (got.status !== want.status || got.addr !== want.addr) begin
                  $display("%0t: mismatch expected status=%0d addr=%h actual status=%0d addr=%h",
                           $time, want.status, want.addr, got.status, got.addr);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

@@ sim/tb_unit_table_block_allocator.sv @@
// Testbench top of the unit table block allocator: clock, reset, stimulus, verdict.
`timescale 1ns / 100ps
module tb_unit_table_block_allocator;
   import utba_pkg::*;

   localparam int RUN_LIMIT = 20_000_000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [31:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic        req_mode;
   logic [15:0] req_request_bytes;
   logic [31:0] req_free_address;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_status;
   logic [31:0] rsp_block_address;
   int          fail_count;
   int          pending_count;
   int          cycle_count;

   // addresses handed out by allocate beats; used to build well-formed frees
   logic [31:0] live_blocks [$];
   logic [31:0] cur_base;
   bit          quiet_phase;
   bit          hold_rsp;
   int          hold_cycles;

   unit_table_block_allocator dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_request_bytes(req_request_bytes), .req_free_address(req_free_address),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_block_address(rsp_block_address)
   );

   utba_checker checker_i (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_request_bytes(req_request_bytes), .req_free_address(req_free_address),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_block_address(rsp_block_address),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Track allocated addresses so later frees can target real blocks.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && rsp_status == 1'b0 && rsp_block_address != 0)
         live_blocks.push_back(rsp_block_address);
   end

   // Watchdog: end the run at a generous cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Receiver: random stall bursts, a long hold-off on request, none at the end.
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   // Drive one request beat and hold it until accepted; valid stays high into the
   // next beat unless an idle burst follows.
   task automatic send_beat(logic m, logic [15:0] nb, logic [31:0] fa);
      req_mode          <= m;
      req_request_bytes <= nb;
      req_free_address  <= fa;
      req_valid         <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
   endtask

   task automatic drain_idle();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      // pending_count already covers every accepted request until its response beat
      repeat (400) @(negedge clock);
   endtask

   task automatic write_base(logic [31:0] b);
      drain_idle();
      csr_we    <= 1'b1;
      csr_wdata <= b;
      @(negedge clock);
      csr_we    <= 1'b0;
      cur_base = b;
      live_blocks.delete();
   endtask

   // Mostly small allocates and frees of live blocks; some junk frees.
   task automatic random_beat();
      int sel, k;
      logic [31:0] a;
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
         if ($urandom_range(0, 19) == 0)
            send_beat(1'b0, 16'($urandom()), 32'($urandom()));
         else
            send_beat(1'b0, 16'($urandom_range(1, 400)), 32'($urandom()));
      end else if (sel < 88 && live_blocks.size() > 0) begin
         k = $urandom_range(0, live_blocks.size() - 1);
         a = live_blocks[k];
         live_blocks.delete(k);
         send_beat(1'b1, 16'($urandom()), a);
      end else begin
         case ($urandom_range(0, 3))
            0: a = 32'($urandom());
            1: a = cur_base + 32'($urandom_range(0, UNITS - 1) * UNIT_BYTES);
            2: a = cur_base + 32'($urandom_range(0, UNITS * UNIT_BYTES - 1));
            default: a = 32'd0;
         endcase
         send_beat(1'b1, 16'($urandom()), a);
      end
   endtask

   initial begin
      logic [31:0] bases [4];
      bases = '{32'h0000_1000, 32'hFFFF_F000, 32'hFFFF_FFE0, 32'h1234_5600};
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_mode = 1'b0;
      req_request_bytes = '0;
      req_free_address = '0;
      quiet_phase = 1'b0;
      hold_rsp = 1'b0;
      hold_cycles = 0;
      cycle_count = 0;
      cur_base = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed: zero size, one unit, exact units, oversize, max, bad frees, a valid free
      send_beat(1'b0, 16'd0, 32'd0);
      send_beat(1'b0, 16'd1, 32'd0);
      send_beat(1'b0, 16'd32, 32'd0);
      send_beat(1'b0, 16'd33, 32'd0);
      send_beat(1'b0, 16'd2048, 32'd0);
      send_beat(1'b0, 16'hFFFF, 32'hFFFF_FFFF);
      send_beat(1'b0, 16'd31744, 32'd0);
      send_beat(1'b1, 16'd0, 32'd0);
      send_beat(1'b1, 16'd0, 32'd1);
      send_beat(1'b1, 16'd0, 32'hFFFF_FFFF);
      send_beat(1'b1, 16'd0, 32'd32 * 1023);
      drain_idle();
      // free the live blocks in allocation order, then double-free one
      while (live_blocks.size() > 0) send_beat(1'b1, 16'hFFFF, live_blocks.pop_front());
      send_beat(1'b1, 16'd0, 32'd32 * 1022);
      // fill to the reserved top so an end entry has no free unit ahead
      send_beat(1'b0, 16'd31744, 32'd0);
      send_beat(1'b0, 16'd1, 32'd0);
      drain_idle();
      while (live_blocks.size() > 0) send_beat(1'b1, 16'd0, live_blocks.pop_front());

      // random phases over several pool bases, the extremes among them
      for (int ph = 0; ph < 4; ph++) begin
         write_base(bases[ph]);
         if (ph == 1) begin
            hold_cycles = 3000;
            hold_rsp = 1'b1;
         end
         for (int n = 0; n < 250; n++) begin
            random_beat();
            if (ph == 2 && n == 100) drain_idle();
         end
      end
      write_base(32'd0);
      quiet_phase = 1'b1;
      for (int n = 0; n < 200; n++) random_beat();

      drain_idle();
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ sim.f @@
sv/utba_pkg.sv
sv/utba_ctrl.sv
sv/utba_dp.sv
sv/unit_table_block_allocator.sv
sim/utba_checker.sv
sim/tb_unit_table_block_allocator.sv
